/* hdl/dtsc_pkg.sv */
// Shared constants and types for the DNA tile saturating counter.
`default_nettype none

package dtsc_pkg;

  // Tile geometry.
  localparam int MAX_TILE_BASES_DEFAULT = 10;
  localparam int MIN_TILE_BASES         = 8;

  // Field and register widths.
  localparam int BASE_W      = 2;
  localparam int COUNT_W     = 16;
  localparam int TILE_SIZE_W = 4;
  localparam int PHASE_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [TILE_SIZE_W-1:0] TILE_SIZE_RESET   = 4'd10;
  localparam logic [COUNT_W-1:0]     MAX_PATTERN_RESET = 16'd1024;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PATTERN = 2'd1;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Status of the tile queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

/* hdl/dtsc_ram.sv */
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module dtsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/dtsc_front.sv */
// Front end: accepts bases, packs them into tiles and queues completed tiles.
`default_nettype none

module dtsc_front #(
  parameter int MAX_TILE_BASES = dtsc_pkg::MAX_TILE_BASES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dtsc_pkg::BASE_W-1:0]         base_code,
  input  wire logic                                seq_start,
  input  wire logic [dtsc_pkg::TILE_SIZE_W-1:0]    tile_size,
  input  wire logic                                clearing,
  input  wire dtsc_pkg::queue_status_t             q_status,
  output logic                                     push,
  output logic      [2*MAX_TILE_BASES-1:0]         push_code
);

  localparam int CODE_W = 2 * MAX_TILE_BASES;
  localparam logic [dtsc_pkg::PHASE_W-1:0] SIZE_MIN =
    dtsc_pkg::PHASE_W'(dtsc_pkg::MIN_TILE_BASES);
  localparam logic [dtsc_pkg::PHASE_W-1:0] SIZE_MAX = dtsc_pkg::PHASE_W'(MAX_TILE_BASES);

  logic [dtsc_pkg::PHASE_W-1:0] phase_count;
  logic [dtsc_pkg::PHASE_W-1:0] phase_count_next;
  logic [CODE_W-1:0]            tile_shift;
  logic [CODE_W-1:0]            tile_shift_next;

  logic                         accept;
  logic [dtsc_pkg::PHASE_W-1:0] size_eff;
  logic [dtsc_pkg::PHASE_W-1:0] phase_base;
  logic [dtsc_pkg::PHASE_W-1:0] phase_inc;
  logic [CODE_W-1:0]            shift_base;
  logic [CODE_W-1:0]            shift_inc;
  logic [CODE_W-1:0]            code_mask;
  logic                         tile_done;

  // Hold bases back while the count table is being cleared or the queue is full.
  assign in_stall = clearing | q_status.full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    priority if (tile_size < SIZE_MIN) begin
      size_eff = SIZE_MIN;
    end else if (tile_size > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = tile_size;
    end
  end

  always_comb begin
    phase_base = seq_start ? '0 : phase_count;
    shift_base = seq_start ? '0 : tile_shift;
    phase_inc  = phase_base + dtsc_pkg::PHASE_W'(1);
    shift_inc  = {shift_base[CODE_W-3:0], base_code};
    code_mask  = ~({CODE_W{1'b1}} << {size_eff, 1'b0});
    tile_done  = (phase_inc >= size_eff);
  end

  always_comb begin
    phase_count_next = phase_count;
    tile_shift_next  = tile_shift;
    if (accept) begin
      if (tile_done) begin
        phase_count_next = '0;
        tile_shift_next  = '0;
      end else begin
        phase_count_next = phase_inc;
        tile_shift_next  = shift_inc;
      end
    end
  end

  assign push      = accept & tile_done;
  assign push_code = shift_inc & code_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      tile_shift  <= '0;
    end else begin
      phase_count <= phase_count_next;
      tile_shift  <= tile_shift_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/dtsc_queue.sv */
// Short FIFO of completed tile codes between the front and the back.
`default_nettype none

module dtsc_queue #(
  parameter int WIDTH = 20,
  parameter int DEPTH = dtsc_pkg::QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic [WIDTH-1:0]        push_data,
  input  wire logic                    pop,
  output logic      [WIDTH-1:0]        head_data,
  output dtsc_pkg::queue_status_t      status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/dtsc_back.sv */
// Back end: clears the count table, then does the saturating read-modify-write per tile.
`default_nettype none

module dtsc_back #(
  parameter int MAX_TILE_BASES = dtsc_pkg::MAX_TILE_BASES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [dtsc_pkg::COUNT_W-1:0]     max_pattern,
  input  wire dtsc_pkg::queue_status_t          q_status,
  input  wire logic [2*MAX_TILE_BASES-1:0]      head_code,
  output logic                                  pop,
  output logic                                  clearing,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [2*MAX_TILE_BASES-1:0]      tile_code,
  output logic      [dtsc_pkg::COUNT_W-1:0]     tile_count,
  output logic                                  overused
);

  localparam int CODE_W = 2 * MAX_TILE_BASES;
  localparam int DEPTH  = 1 << CODE_W;

  dtsc_pkg::back_state_t state;
  dtsc_pkg::back_state_t state_next;

  logic [CODE_W-1:0]            clr_addr;
  logic [CODE_W-1:0]            code_hold;
  logic [dtsc_pkg::COUNT_W-1:0] rd_count;
  logic [dtsc_pkg::COUNT_W-1:0] count_new;

  logic                         slot_free;
  logic                         finish;
  logic                         ram_wr_en;
  logic [CODE_W-1:0]            ram_wr_addr;
  logic [dtsc_pkg::COUNT_W-1:0] ram_wr_data;

  assign clearing  = (state == dtsc_pkg::ST_CLEAR);
  assign slot_free = ~out_valid | ~out_stall;
  assign pop       = (state == dtsc_pkg::ST_IDLE) & ~q_status.empty;
  assign finish    = (state == dtsc_pkg::ST_UPDATE) & slot_free;
  assign count_new = (rd_count < max_pattern) ? rd_count + dtsc_pkg::COUNT_W'(1) : rd_count;

  always_comb begin
    ram_wr_en   = clearing | finish;
    ram_wr_addr = clearing ? clr_addr : code_hold;
    ram_wr_data = clearing ? '0 : count_new;
  end

  dtsc_ram #(
    .WIDTH (dtsc_pkg::COUNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (pop),
    .rd_addr (head_code),
    .rd_data (rd_count)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      dtsc_pkg::ST_CLEAR: begin
        if (clr_addr == {CODE_W{1'b1}}) begin
          state_next = dtsc_pkg::ST_IDLE;
        end
      end
      dtsc_pkg::ST_IDLE: begin
        if (pop) begin
          state_next = dtsc_pkg::ST_UPDATE;
        end
      end
      dtsc_pkg::ST_UPDATE: begin
        if (slot_free) begin
          state_next = dtsc_pkg::ST_IDLE;
        end
      end
      default: state_next = dtsc_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dtsc_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + CODE_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      code_hold <= head_code;
    end
    if (finish) begin
      tile_code  <= code_hold;
      tile_count <= count_new;
      overused   <= (count_new >= max_pattern);
    end
  end

endmodule

`default_nettype wire

/* hdl/dna_tile_saturating_counter.sv */
// Top level of the DNA tile saturating counter: registers, front, queue and back.
// A completed tile passes through the queue, the RAM read and the result register.
// One base per cycle is taken unless in_stall; the back updates one tile at a time.
// Reset clears the tiling state and sets tile_size to 10 and max_pattern to 1024.
// After reset the count table is zeroed one entry a cycle, all 2^(2*MAX_TILE_BASES)
// entries (1048576 by default), and no base is accepted until that pass is over.
`default_nettype none

module dna_tile_saturating_counter #(
  parameter int MAX_TILE_BASES = dtsc_pkg::MAX_TILE_BASES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Base input channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dtsc_pkg::BASE_W-1:0]         base_code,
  input  wire logic                                seq_start,
  // Tile result channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [2*MAX_TILE_BASES-1:0]         tile_code,
  output logic      [dtsc_pkg::COUNT_W-1:0]        tile_count,
  output logic                                     overused,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dtsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [dtsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CODE_W = 2 * MAX_TILE_BASES;

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is accepted and has no effect.
  logic [dtsc_pkg::TILE_SIZE_W-1:0] tile_size;
  logic [dtsc_pkg::COUNT_W-1:0]     max_pattern;

  // Queue between the front and the back.
  dtsc_pkg::queue_status_t q_status;
  logic                    push;
  logic [CODE_W-1:0]       push_code;
  logic                    pop;
  logic [CODE_W-1:0]       head_code;
  logic                    clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= dtsc_pkg::TILE_SIZE_RESET;
      max_pattern <= dtsc_pkg::MAX_PATTERN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == dtsc_pkg::REG_TILE_SIZE) begin
        tile_size <= cfg_data[dtsc_pkg::TILE_SIZE_W-1:0];
      end else if (cfg_index == dtsc_pkg::REG_MAX_PATTERN) begin
        max_pattern <= cfg_data[dtsc_pkg::COUNT_W-1:0];
      end
    end
  end

  // The front packs bases into tiles. It never waits on the table update:
  // it only stalls when the queue is full or the table is being cleared.
  dtsc_front #(
    .MAX_TILE_BASES (MAX_TILE_BASES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .base_code (base_code),
    .seq_start (seq_start),
    .tile_size (tile_size),
    .clearing  (clearing),
    .q_status  (q_status),
    .push      (push),
    .push_code (push_code)
  );

  // Completed tiles wait here while the back works through earlier ones or
  // the result register is held by a stalled consumer.
  dtsc_queue #(
    .WIDTH (CODE_W),
    .DEPTH (dtsc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_code),
    .pop       (pop),
    .head_data (head_code),
    .status    (q_status)
  );

  // The back reads the tile's count, applies the saturating increment,
  // writes it back and loads the result register. Updates are strictly one
  // after another, so a write always lands before the next read is issued.
  dtsc_back #(
    .MAX_TILE_BASES (MAX_TILE_BASES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_pattern (max_pattern),
    .q_status    (q_status),
    .head_code   (head_code),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tile_code   (tile_code),
    .tile_count  (tile_count),
    .overused    (overused)
  );

endmodule

`default_nettype wire
